/* src/sftl_pkg.sv */
// Shared types and constants for the symmetric flow table lookup.
// Used by sftl_hash, sftl_probe and the top module; depends on nothing else.

package sftl_pkg;

    // Default table and probe geometry.
    localparam int unsigned DEF_TABLE_SLOTS = 65536;
    localparam int unsigned DEF_PROBE_LIMIT = 16;

    // Size register: reset value, lower clamp and word index on the port.
    localparam logic [4:0] LOG2_RESET = 5'd16;
    localparam logic [4:0] LOG2_MIN   = 5'd10;
    localparam logic       REG_TABLE_SIZE_LOG2 = 1'b0;

    // FNV-1a-64 constants; the prime is 2^40 + 0x1B3.
    localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;
    localparam int unsigned FNV_PRIME_SH = 40;

    // Splitmix64 finalizer multipliers.
    localparam logic [63:0] MIX_C1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C2 = 64'h94D0_49BB_1331_11EB;

    // One packet 5-tuple.
    typedef struct packed {
        logic        is_ipv6;
        logic [7:0]  protocol;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_key;

    // One table slot as stored in memory.
    typedef struct packed {
        logic valid;
        t_key key;
    } t_entry;

endpackage

/* src/sftl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the probe engine for the slot table.

module sftl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sftl_hash.sv */
// Front end: accepts a 5-tuple and computes its direction-symmetric 64-bit hash.
// Uses sftl_pkg for the key type and the hash constants.

module sftl_hash (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sftl_pkg::t_key  i_key,
    output logic            o_valid,
    input  logic            i_ready,
    output sftl_pkg::t_key  o_key,
    output logic [63:0]     o_hash
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FNV,
        ST_MIX,
        ST_COMB,
        ST_DONE
    } t_state;

    // Which hash pass is running.
    localparam logic [1:0] PASS_SRC   = 2'd0;
    localparam logic [1:0] PASS_DST   = 2'd1;
    localparam logic [1:0] PASS_FINAL = 2'd2;

    t_state         r_state;
    logic [1:0]     r_pass;
    logic [3:0]     r_k;
    logic [3:0]     r_ms;
    logic [63:0]    r_x;
    logic [63:0]    r_acc;
    logic [63:0]    r_a;
    sftl_pkg::t_key r_key;

    logic [63:0] w_hi;
    logic [63:0] w_lo;
    logic [63:0] w_word;
    logic [15:0] w_port;
    logic [5:0]  w_bidx;
    logic [7:0]  w_byte;
    logic [63:0] w_x1;
    logic [63:0] w_small;
    logic [63:0] w_fnv;
    logic [3:0]  w_last;
    logic [63:0] w_c;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;

    // Address and port of the side being hashed.
    always_comb begin
        if (r_pass == PASS_DST) begin
            w_hi   = r_key.dst_addr_hi;
            w_lo   = r_key.dst_addr_lo;
            w_port = r_key.dport;
        end else begin
            w_hi   = r_key.src_addr_hi;
            w_lo   = r_key.src_addr_lo;
            w_port = r_key.sport;
        end
    end

    // One FNV-1a byte step; the prime multiply is a shift plus a small product.
    assign w_word  = r_k[3] ? w_lo : w_hi;
    assign w_bidx  = {3'd7 - r_k[2:0], 3'b000};
    assign w_byte  = w_word[w_bidx +: 8];
    assign w_x1    = r_x ^ {56'd0, w_byte};
    assign w_small = w_x1 * 64'(sftl_pkg::FNV_PRIME_LO);
    assign w_fnv   = (w_x1 << sftl_pkg::FNV_PRIME_SH) + w_small;
    assign w_last  = r_key.is_ipv6 ? 4'd15 : 4'd3;

    // One 32x32 partial product per cycle for the finalizer multiplies.
    assign w_c     = (r_ms <= 4'd3) ? sftl_pkg::MIX_C1 : sftl_pkg::MIX_C2;
    assign w_mul_a = (r_ms == 4'd3 || r_ms == 4'd7) ? r_x[63:32] : r_x[31:0];
    assign w_mul_b = (r_ms == 4'd2 || r_ms == 4'd6) ? w_c[63:32] : w_c[31:0];
    assign w_prod  = w_mul_a * w_mul_b;

    // Sequencer: source pass, destination pass, combine, final mix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= PASS_SRC;
            r_k     <= '0;
            r_ms    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_key   <= i_key;
                        r_pass  <= PASS_SRC;
                        r_k     <= '0;
                        r_x     <= sftl_pkg::FNV_BASIS;
                        r_state <= ST_FNV;
                    end
                end
                ST_FNV: begin
                    if (r_k == w_last) begin
                        r_x     <= w_fnv ^ {48'd0, w_port};
                        r_ms    <= '0;
                        r_state <= ST_MIX;
                    end else begin
                        r_x <= w_fnv;
                        r_k <= r_k + 4'd1;
                    end
                end
                ST_MIX: begin
                    r_ms <= r_ms + 4'd1;
                    case (r_ms)
                        4'd0:       r_x   <= r_x ^ (r_x >> 30);
                        4'd1, 4'd5: r_acc <= w_prod;
                        4'd2, 4'd6: r_acc <= r_acc + {w_prod[31:0], 32'd0};
                        4'd3, 4'd7: r_x   <= r_acc + {w_prod[31:0], 32'd0};
                        4'd4:       r_x   <= r_x ^ (r_x >> 27);
                        4'd8: begin
                            if (r_pass == PASS_SRC) begin
                                r_a     <= r_x ^ (r_x >> 31);
                                r_pass  <= PASS_DST;
                                r_k     <= '0;
                                r_x     <= sftl_pkg::FNV_BASIS;
                                r_state <= ST_FNV;
                            end else if (r_pass == PASS_DST) begin
                                r_x     <= r_x ^ (r_x >> 31);
                                r_state <= ST_COMB;
                            end else begin
                                r_x     <= r_x ^ (r_x >> 31);
                                r_state <= ST_DONE;
                            end
                        end
                        default: r_x <= r_x;
                    endcase
                end
                ST_COMB: begin
                    r_x     <= (r_a ^ r_x) + (r_a & r_x) + {56'd0, r_key.protocol};
                    r_pass  <= PASS_FINAL;
                    r_ms    <= '0;
                    r_state <= ST_MIX;
                end
                ST_DONE: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_key   = r_key;
    assign o_hash  = r_x;

endmodule

/* src/sftl_fifo.sv */
// Two-entry queue between the hash front end and the probe engine.
// Stand-alone; carries an opaque payload word.

module sftl_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* src/sftl_probe.sv */
// Back end: clears the slot table after reset, then probes, installs or evicts.
// Uses sftl_pkg for the key and entry types and sftl_ram for the table.

module sftl_probe #(
    parameter int unsigned SLOT_W      = 16,
    parameter int unsigned PROBE_LIMIT = sftl_pkg::DEF_PROBE_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_mask,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  sftl_pkg::t_key    i_job_key,
    input  logic [SLOT_W-1:0] i_job_home,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_slot_index,
    output logic              o_is_new,
    output logic              o_evicted,
    output logic [16:0]       o_flow_count,
    output logic [31:0]       o_eviction_count
);

    localparam int unsigned P_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
    localparam int unsigned E_W = $bits(sftl_pkg::t_entry);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_OUT
    } t_state;

    t_state            r_state;
    sftl_pkg::t_key    r_key;
    logic [SLOT_W-1:0] r_home;
    logic [SLOT_W-1:0] r_cur;
    logic [P_W-1:0]    r_p;
    logic [SLOT_W-1:0] r_res_slot;
    logic              r_res_new;
    logic              r_res_evict;
    logic [16:0]       r_installed;
    logic [31:0]       r_evictions;
    logic              r_out_valid;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_new;
    logic              r_out_evict;
    logic [16:0]       r_out_fc;
    logic [31:0]       r_out_ec;

    logic                 w_we;
    logic [SLOT_W-1:0]    w_waddr;
    logic [E_W-1:0]       w_wdata;
    logic [E_W-1:0]       w_rdata;
    sftl_pkg::t_entry     w_ent;
    sftl_pkg::t_entry     w_new_ent;
    logic                 w_meta_eq;
    logic                 w_fwd;
    logic                 w_rev;
    logic                 w_hit;
    logic                 w_last;

    // Address compare: IPv4 keys use only the top four bytes of the high word.
    function automatic logic addr_eq(input logic [63:0] ahi, input logic [63:0] alo,
                                     input logic [63:0] bhi, input logic [63:0] blo,
                                     input logic v6);
        logic eq;
        if (v6) begin
            eq = (ahi == bhi) && (alo == blo);
        end else begin
            eq = (ahi[63:32] == bhi[63:32]);
        end
        return eq;
    endfunction

    sftl_ram #(
        .WIDTH (E_W),
        .DEPTH (2 ** SLOT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (r_state == ST_RD),
        .i_raddr (r_cur),
        .o_rdata (w_rdata)
    );

    // Key match against the slot just read, forward or reversed.
    assign w_ent     = sftl_pkg::t_entry'(w_rdata);
    assign w_meta_eq = (w_ent.key.is_ipv6 == r_key.is_ipv6) &&
                       (w_ent.key.protocol == r_key.protocol);
    assign w_fwd = (w_ent.key.sport == r_key.sport) &&
                   (w_ent.key.dport == r_key.dport) &&
                   addr_eq(w_ent.key.src_addr_hi, w_ent.key.src_addr_lo,
                           r_key.src_addr_hi, r_key.src_addr_lo, r_key.is_ipv6) &&
                   addr_eq(w_ent.key.dst_addr_hi, w_ent.key.dst_addr_lo,
                           r_key.dst_addr_hi, r_key.dst_addr_lo, r_key.is_ipv6);
    assign w_rev = (w_ent.key.sport == r_key.dport) &&
                   (w_ent.key.dport == r_key.sport) &&
                   addr_eq(w_ent.key.src_addr_hi, w_ent.key.src_addr_lo,
                           r_key.dst_addr_hi, r_key.dst_addr_lo, r_key.is_ipv6) &&
                   addr_eq(w_ent.key.dst_addr_hi, w_ent.key.dst_addr_lo,
                           r_key.src_addr_hi, r_key.src_addr_lo, r_key.is_ipv6);
    assign w_hit  = w_ent.valid && w_meta_eq && (w_fwd || w_rev);
    assign w_last = (r_p == P_W'(PROBE_LIMIT - 1));

    // Table writes: clearing pass, install into an empty slot, or eviction.
    assign w_new_ent.valid = 1'b1;
    assign w_new_ent.key   = r_key;
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cur;
        w_wdata = w_new_ent;
        if (r_state == ST_CLR) begin
            w_we    = 1'b1;
            w_wdata = '0;
        end else if (r_state == ST_CMP) begin
            if (!w_ent.valid) begin
                w_we = 1'b1;
            end else if (!w_hit && w_last) begin
                w_we    = 1'b1;
                w_waddr = r_home;
            end
        end
    end

    // Probe sequencer, counters and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cur       <= '0;
            r_p         <= '0;
            r_installed <= '0;
            r_evictions <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The output state reloads the register itself when the beat leaves.
            if (r_out_valid && i_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLR: begin
                    r_cur <= r_cur + SLOT_W'(1);
                    if (&r_cur) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_key   <= i_job_key;
                        r_home  <= i_job_home & i_mask;
                        r_cur   <= i_job_home & i_mask;
                        r_p     <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (!w_ent.valid) begin
                        r_res_slot  <= r_cur;
                        r_res_new   <= 1'b1;
                        r_res_evict <= 1'b0;
                        if (!(&r_installed)) begin
                            r_installed <= r_installed + 17'd1;
                        end
                        r_state <= ST_OUT;
                    end else if (w_hit) begin
                        r_res_slot  <= r_cur;
                        r_res_new   <= 1'b0;
                        r_res_evict <= 1'b0;
                        r_state     <= ST_OUT;
                    end else if (w_last) begin
                        r_res_slot  <= r_home;
                        r_res_new   <= 1'b1;
                        r_res_evict <= 1'b1;
                        if (!(&r_evictions)) begin
                            r_evictions <= r_evictions + 32'd1;
                        end
                        r_state <= ST_OUT;
                    end else begin
                        r_p     <= r_p + P_W'(1);
                        r_cur   <= (r_cur + SLOT_W'(1)) & i_mask;
                        r_state <= ST_RD;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_slot  <= r_res_slot;
                        r_out_new   <= r_res_new;
                        r_out_evict <= r_res_evict;
                        r_out_fc    <= r_installed;
                        r_out_ec    <= r_evictions;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_job_ready      = (r_state == ST_IDLE);
    assign o_valid          = r_out_valid;
    assign o_slot_index     = 16'(r_out_slot);
    assign o_is_new         = r_out_new;
    assign o_evicted        = r_out_evict;
    assign o_flow_count     = r_out_fc;
    assign o_eviction_count = r_out_ec;

endmodule

/* src/symmetric_flow_table_lookup.sv */
// Symmetric flow table lookup: finds or installs a packet 5-tuple in a hashed slot
// table and reports the slot, the new and evicted flags and the running counts.
// After reset the block first clears all 2^SLOT_W slots (65536 at the default
// size), one slot per cycle, and starts no lookup until then; the hash front end
// and the queue still take up to three beats meanwhile, and register writes are
// taken too. The hash front end is iterative: one address byte per cycle and a
// finalizer that uses one 32x32 multiplier; it takes no new item until the last
// one has left it. The probe engine runs behind a two-entry queue; each probed
// slot takes a table read and a compare, up to PROBE_LIMIT slots per item, and it
// takes no new job until the result of the last one is registered. The size
// register must be written only while the block is idle.
// Depends on sftl_pkg, sftl_hash, sftl_fifo, sftl_probe and sftl_ram.

module symmetric_flow_table_lookup #(
    parameter int unsigned TABLE_SLOTS = sftl_pkg::DEF_TABLE_SLOTS,
    parameter int unsigned PROBE_LIMIT = sftl_pkg::DEF_PROBE_LIMIT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_is_ipv6,
    input  logic [7:0]  i_protocol,
    input  logic [63:0] i_src_addr_hi,
    input  logic [63:0] i_src_addr_lo,
    input  logic [63:0] i_dst_addr_hi,
    input  logic [63:0] i_dst_addr_lo,
    input  logic [15:0] i_sport,
    input  logic [15:0] i_dport,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_slot_index,
    output logic        o_is_new,
    output logic        o_evicted,
    output logic [16:0] o_flow_count,
    output logic [31:0] o_eviction_count
);

    // Slots actually addressed: the largest power of two within TABLE_SLOTS.
    localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS + 1) - 1;
    localparam int unsigned JOB_W  = $bits(sftl_pkg::t_key) + SLOT_W;

    logic [4:0]        r_log2;
    logic [4:0]        w_log2_c;
    logic [SLOT_W-1:0] w_mask;
    logic              w_cfg_we;

    sftl_pkg::t_key    w_in_key;
    logic              w_h_valid;
    logic              w_h_ready;
    sftl_pkg::t_key    w_h_key;
    logic [63:0]       w_h_hash;
    logic              w_q_valid;
    logic              w_q_ready;
    logic [JOB_W-1:0]  w_q_data;

    // Size register; written on the access phase of a write.
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= sftl_pkg::LOG2_RESET;
        end else if (w_cfg_we && (paddr[2] == sftl_pkg::REG_TABLE_SIZE_LOG2)) begin
            r_log2 <= pwdata[4:0];
        end
    end
    assign prdata = (paddr[2] == sftl_pkg::REG_TABLE_SIZE_LOG2) ? {27'd0, r_log2} : 32'd0;

    // Clamp the size and build the index mask.
    always_comb begin
        if (r_log2 < sftl_pkg::LOG2_MIN) begin
            w_log2_c = sftl_pkg::LOG2_MIN;
        end else if (r_log2 > 5'(SLOT_W)) begin
            w_log2_c = 5'(SLOT_W);
        end else begin
            w_log2_c = r_log2;
        end
    end
    assign w_mask = ~({SLOT_W{1'b1}} << w_log2_c);

    // Gather the input beat.
    assign w_in_key.is_ipv6     = i_is_ipv6;
    assign w_in_key.protocol    = i_protocol;
    assign w_in_key.src_addr_hi = i_src_addr_hi;
    assign w_in_key.src_addr_lo = i_src_addr_lo;
    assign w_in_key.dst_addr_hi = i_dst_addr_hi;
    assign w_in_key.dst_addr_lo = i_dst_addr_lo;
    assign w_in_key.sport       = i_sport;
    assign w_in_key.dport       = i_dport;

    sftl_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_key   (w_in_key),
        .o_valid (w_h_valid),
        .i_ready (w_h_ready),
        .o_key   (w_h_key),
        .o_hash  (w_h_hash)
    );

    sftl_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_valid),
        .o_ready (w_h_ready),
        .i_data  ({w_h_key, w_h_hash[SLOT_W-1:0]}),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_data)
    );

    sftl_probe #(
        .SLOT_W      (SLOT_W),
        .PROBE_LIMIT (PROBE_LIMIT)
    ) u_probe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mask           (w_mask),
        .i_job_valid      (w_q_valid),
        .o_job_ready      (w_q_ready),
        .i_job_key        (sftl_pkg::t_key'(w_q_data[JOB_W-1:SLOT_W])),
        .i_job_home       (w_q_data[SLOT_W-1:0]),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_slot_index     (o_slot_index),
        .o_is_new         (o_is_new),
        .o_evicted        (o_evicted),
        .o_flow_count     (o_flow_count),
        .o_eviction_count (o_eviction_count)
    );

endmodule
